FILE: hdl/psc_pkg.sv
// Package for the PRBS memory scrub checker: sizes, op codes and the word
// record that the front end hands to the back end through the queue.
// No dependencies.
`default_nettype none

package psc_pkg;

    // Golden memory depth in words, and the address width it needs.
    localparam int WORDS  = 16384;
    localparam int MEM_AW = (WORDS > 1) ? $clog2(WORDS) : 1;

    // Field widths.
    localparam int IDX_W   = 14;
    localparam int WORD_W  = 64;
    localparam int FLIPS_W = 7;
    localparam int TOTAL_W = 21;

    localparam logic [6:0]         PRBS_SEED = 7'h7F;
    localparam logic [TOTAL_W-1:0] FLIP_MAX  = {TOTAL_W{1'b1}};

    // Op codes; the fourth code only reports the current totals.
    localparam logic [1:0] OP_FILL    = 2'd0;
    localparam logic [1:0] OP_CHECK   = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;

    // Queue between front and back end.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // One classified word on its way to the back end.
    typedef struct packed {
        logic [1:0]         op;
        logic [WORD_W-1:0]  write_word;
        logic               write_enable;
        logic [FLIPS_W-1:0] word_flips;
        logic               pass_last;
        logic [WORD_W-1:0]  read_word;
        logic [WORD_W-1:0]  fill_sum;
    } q_entry_t;

endpackage

`default_nettype wire

FILE: hdl/psc_front.sv
// Front end: accepts input words, runs the PRBS generator and the expected
// sum, holds the golden memory and classifies each word. Uses psc_pkg.
`default_nettype none

module psc_front
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [1:0]                 in_op,
    input  wire logic [psc_pkg::IDX_W-1:0]  in_index,
    input  wire logic [psc_pkg::WORD_W-1:0] in_read_word,
    input  wire logic                       in_last,
    output logic                            push_valid,
    input  wire logic                       push_ready,
    output psc_pkg::q_entry_t               push_entry
);

    // Eight PRBS steps, state after each step in its own byte, first in byte 0.
    function automatic logic [psc_pkg::WORD_W-1:0] prbs8(input logic [6:0] seed);
        logic [6:0]                  s;
        logic [psc_pkg::WORD_W-1:0]  w;
        s = seed;
        w = '0;
        for (int j = 0; j < 8; j++)
        begin
            s = {s[5:0], s[6] ^ s[5]};
            w[8*j +: 8] = {1'b0, s};
        end
        return w;
    endfunction

    function automatic logic [psc_pkg::FLIPS_W-1:0] popcount(
        input logic [psc_pkg::WORD_W-1:0] x);
        logic [psc_pkg::FLIPS_W-1:0] n;
        n = '0;
        for (int i = 0; i < psc_pkg::WORD_W; i++)
        begin
            n = n + psc_pkg::FLIPS_W'(x[i]);
        end
        return n;
    endfunction

    logic [psc_pkg::WORD_W-1:0] golden_mem [0:psc_pkg::WORDS-1];

    logic [6:0]                 lfsr_reg, lfsr_next;
    logic [psc_pkg::WORD_W-1:0] fill_sum_reg, fill_sum_next;

    logic                       s1_valid_reg;
    logic [1:0]                 s1_op_reg;
    logic                       s1_in_range_reg;
    logic                       s1_last_reg;
    logic [psc_pkg::WORD_W-1:0] s1_read_reg;
    logic [psc_pkg::WORD_W-1:0] s1_gen_reg;
    logic [psc_pkg::WORD_W-1:0] s1_fsum_reg;
    logic [psc_pkg::WORD_W-1:0] gold_reg;

    logic                       accept;
    logic                       in_range;
    logic [psc_pkg::MEM_AW-1:0] mem_addr;
    logic [psc_pkg::WORD_W-1:0] gen_word;
    logic [psc_pkg::WORD_W-1:0] gold;
    logic [psc_pkg::WORD_W-1:0] diff;

    assign in_ready = !s1_valid_reg || push_ready;
    assign accept   = in_valid && in_ready;
    assign in_range = ({3'b000, in_index} < 17'(psc_pkg::WORDS));
    assign mem_addr = psc_pkg::MEM_AW'({{psc_pkg::MEM_AW{1'b0}}, in_index});
    assign gen_word = prbs8(lfsr_reg);

    always_comb
    begin
        lfsr_next     = lfsr_reg;
        fill_sum_next = fill_sum_reg;
        case (in_op)
            psc_pkg::OP_FILL:
            begin
                lfsr_next     = gen_word[62:56];
                fill_sum_next = fill_sum_reg + gen_word;
            end
            psc_pkg::OP_RESTART:
            begin
                lfsr_next     = psc_pkg::PRBS_SEED;
                fill_sum_next = '0;
            end
            default:
            begin
                lfsr_next     = lfsr_reg;
                fill_sum_next = fill_sum_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lfsr_reg     <= psc_pkg::PRBS_SEED;
            fill_sum_reg <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                lfsr_reg     <= lfsr_next;
                fill_sum_reg <= fill_sum_next;
            end
            if (accept)
                s1_valid_reg <= 1'b1;
            else if (push_ready)
                s1_valid_reg <= 1'b0;
        end
    end

    // Stage 1 payload and the golden memory port.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg       <= in_op;
            s1_in_range_reg <= in_range;
            s1_last_reg     <= in_last;
            s1_read_reg     <= in_read_word;
            s1_gen_reg      <= gen_word;
            s1_fsum_reg     <= fill_sum_next;
            gold_reg        <= golden_mem[mem_addr];
            if (in_op == psc_pkg::OP_FILL && in_range)
                golden_mem[mem_addr] <= gen_word;
        end
    end

    assign gold = s1_in_range_reg ? gold_reg : '0;
    assign diff = s1_read_reg ^ gold;

    always_comb
    begin
        push_entry              = '0;
        push_entry.op           = s1_op_reg;
        push_entry.read_word    = s1_read_reg;
        push_entry.fill_sum     = s1_fsum_reg;
        case (s1_op_reg)
            psc_pkg::OP_FILL:
            begin
                push_entry.write_word   = s1_gen_reg;
                push_entry.write_enable = 1'b1;
            end
            psc_pkg::OP_CHECK:
            begin
                push_entry.write_word   = gold;
                push_entry.write_enable = (diff != '0);
                push_entry.word_flips   = popcount(diff);
                push_entry.pass_last    = s1_last_reg;
            end
            default:
            begin
                push_entry.write_word   = '0;
                push_entry.write_enable = 1'b0;
            end
        endcase
    end

    assign push_valid = s1_valid_reg;

endmodule

`default_nettype wire

FILE: hdl/psc_queue.sv
// Short queue of classified words between the front and the back end.
// Uses psc_pkg for the entry record and depth.
`default_nettype none

module psc_queue
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push_valid,
    output logic                   push_ready,
    input  wire psc_pkg::q_entry_t push_entry,
    output logic                   pop_valid,
    input  wire logic              pop_ready,
    output psc_pkg::q_entry_t      pop_entry
);

    psc_pkg::q_entry_t entries [0:psc_pkg::QUEUE_DEPTH-1];

    logic [psc_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [psc_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [psc_pkg::QPTR_W:0]   count_reg;
    logic                       push;
    logic                       pop;

    assign push_ready = (count_reg != (psc_pkg::QPTR_W+1)'(psc_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_entry  = entries[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entries[wr_ptr_reg] <= push_entry;
    end

endmodule

`default_nettype wire

FILE: hdl/psc_back.sv
// Back end: keeps the read sum and flip count, closes verify passes and
// holds the output register. Uses psc_pkg.
`default_nettype none

module psc_back
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        q_valid,
    output logic                             q_ready,
    input  wire psc_pkg::q_entry_t           q_entry,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [psc_pkg::WORD_W-1:0]       out_write_word,
    output logic                             out_write_enable,
    output logic [psc_pkg::FLIPS_W-1:0]      out_word_flips,
    output logic                             out_pass_done,
    output logic                             out_pass_ok,
    output logic [psc_pkg::TOTAL_W-1:0]      out_flip_total,
    output logic [psc_pkg::WORD_W-1:0]       out_read_sum,
    output logic [psc_pkg::WORD_W-1:0]       out_expected_sum
);

    logic [psc_pkg::WORD_W-1:0]  check_sum_reg, check_sum_next;
    logic [psc_pkg::TOTAL_W-1:0] flip_count_reg, flip_count_next;
    logic                        out_valid_reg;

    logic                        load;
    logic [psc_pkg::WORD_W-1:0]  sum_add;
    logic [psc_pkg::TOTAL_W:0]   cnt_add;
    logic [psc_pkg::TOTAL_W-1:0] cnt_sat;
    logic [psc_pkg::WORD_W-1:0]  rep_sum;
    logic [psc_pkg::TOTAL_W-1:0] rep_total;
    logic                        done;
    logic                        ok;

    assign q_ready   = !out_valid_reg || out_ready;
    assign load      = q_valid && q_ready;
    assign out_valid = out_valid_reg;

    assign sum_add = check_sum_reg + q_entry.read_word;
    assign cnt_add = {1'b0, flip_count_reg} + (psc_pkg::TOTAL_W+1)'(q_entry.word_flips);
    assign cnt_sat = cnt_add[psc_pkg::TOTAL_W] ? psc_pkg::FLIP_MAX
                                               : cnt_add[psc_pkg::TOTAL_W-1:0];

    always_comb
    begin
        rep_sum   = check_sum_reg;
        rep_total = flip_count_reg;
        done      = 1'b0;
        ok        = 1'b0;
        case (q_entry.op)
            psc_pkg::OP_CHECK:
            begin
                rep_sum   = sum_add;
                rep_total = cnt_sat;
                done      = q_entry.pass_last;
                ok        = q_entry.pass_last && (sum_add == q_entry.fill_sum)
                            && (cnt_sat == '0);
            end
            psc_pkg::OP_RESTART:
            begin
                rep_sum   = '0;
                rep_total = '0;
            end
            default:
            begin
                rep_sum   = check_sum_reg;
                rep_total = flip_count_reg;
            end
        endcase
        // A closed pass starts the next one from zero.
        check_sum_next  = done ? '0 : rep_sum;
        flip_count_next = done ? '0 : rep_total;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            check_sum_reg  <= '0;
            flip_count_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                check_sum_reg  <= check_sum_next;
                flip_count_reg <= flip_count_next;
            end
            if (load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_write_word   <= q_entry.write_word;
            out_write_enable <= q_entry.write_enable;
            out_word_flips   <= q_entry.word_flips;
            out_pass_done    <= done;
            out_pass_ok      <= ok;
            out_flip_total   <= rep_total;
            out_read_sum     <= rep_sum;
            out_expected_sum <= q_entry.fill_sum;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/prbs_memory_scrub_checker.sv
// Top level of the PRBS memory scrub checker: front end, queue and back end.
// Uses psc_pkg, psc_front, psc_queue and psc_back.
//
// The checker takes one word per clock cycle while its queue and output
// side keep up, and gives one result word for each input word, in order;
// the single-port golden memory in the front end is read for every word
// and written on fill in the cycle the word is taken. A word is registered
// together with its golden memory read in stage one, moves on into the
// queue and from there into the output register. Op codes on s_tuser are
// fill (0), check (1) and restart (2); code 3 only reports the current
// totals. Fill words run the PRBS-7 generator eight steps on from its
// current state (seed 0x7F after reset or restart), store the packed
// word as the golden copy and return it for writing. Check words compare
// the word read back against the golden copy; s_tlast on a check word
// closes the verify pass, and the result then carries m_tlast, the pass
// verdict and the totals before they are cleared. The golden memory holds
// 16384 words and is not cleared at reset, so a check of a position that
// was never filled gives an undefined comparison. Restart reseeds the
// generator and clears all sums and the flip count but keeps the golden
// memory.
`default_nettype none

module prbs_memory_scrub_checker
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // s_tdata, from bit 0: word_index[13:0], read_word[77:14], zero pad [79:78]
    input  wire logic [79:0]  s_tdata,
    // s_tuser: op[1:0]
    input  wire logic [1:0]   s_tuser,
    // s_tlast: pass_last
    input  wire logic         s_tlast,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // m_tdata, from bit 0: write_word[63:0], write_enable[64], word_flips[71:65],
    // pass_ok[72], flip_total[93:73], read_sum[157:94], expected_sum[221:158],
    // zero pad [223:222]
    output logic [223:0]      m_tdata,
    // m_tlast: pass_done
    output logic              m_tlast
);

    logic              push_valid;
    logic              push_ready;
    psc_pkg::q_entry_t push_entry;
    logic              pop_valid;
    logic              pop_ready;
    psc_pkg::q_entry_t pop_entry;

    logic [psc_pkg::WORD_W-1:0]  write_word;
    logic                        write_enable;
    logic [psc_pkg::FLIPS_W-1:0] word_flips;
    logic                        pass_ok;
    logic [psc_pkg::TOTAL_W-1:0] flip_total;
    logic [psc_pkg::WORD_W-1:0]  read_sum;
    logic [psc_pkg::WORD_W-1:0]  expected_sum;

    psc_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_op        (s_tuser),
        .in_index     (s_tdata[13:0]),
        .in_read_word (s_tdata[77:14]),
        .in_last      (s_tlast),
        .push_valid   (push_valid),
        .push_ready   (push_ready),
        .push_entry   (push_entry)
    );

    psc_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    psc_back u_back
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .q_valid          (pop_valid),
        .q_ready          (pop_ready),
        .q_entry          (pop_entry),
        .out_valid        (m_tvalid),
        .out_ready        (m_tready),
        .out_write_word   (write_word),
        .out_write_enable (write_enable),
        .out_word_flips   (word_flips),
        .out_pass_done    (m_tlast),
        .out_pass_ok      (pass_ok),
        .out_flip_total   (flip_total),
        .out_read_sum     (read_sum),
        .out_expected_sum (expected_sum)
    );

    assign m_tdata = {2'b00, expected_sum, read_sum, flip_total, pass_ok,
                      word_flips, write_enable, write_word};

`ifndef SYNTHESIS
    // A passing verdict only comes with the close of a pass and no flips at all.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && pass_ok) |-> (m_tlast && flip_total == '0 && word_flips == '0))
    else $error("pass_ok without pass close or with flips counted");

    // Any flipped bit in a word asks for the golden word to be rewritten.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && word_flips != '0) |-> write_enable)
    else $error("flipped word without rewrite request");

    // The front end only takes a word while the queue is full if stage one holds nothing.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && !push_ready) |-> !push_valid)
    else $error("input taken while stage one is blocked");
`endif

endmodule

`default_nettype wire

FILE: test/tb_prbs_memory_scrub_checker.sv
// Self-checking testbench for prbs_memory_scrub_checker: directed words and
// random fill/verify passes under four idling patterns.
// Depends on psc_pkg and the checker's RTL.
`timescale 1ns / 1ps

module tb_prbs_memory_scrub_checker;

    // The fourth op code only reports the current totals.
    localparam logic [1:0] OP_REPORT = 2'd3;

    // First fill word after reset: PRBS-7 states 7E 7C 78 70 60 40 01 02,
    // byte 0 in the lowest bits.
    localparam logic [psc_pkg::WORD_W-1:0] FIRST_FILL_WORD = 64'h0201_4060_7078_7C7E;

    // Cycles without any accepted word before the run is declared hung. The
    // slowest legal stretch is a long random stall on both sides plus the
    // pass through the pipeline.
    localparam int HANG_LIMIT = 2000;

    // Words per random phase, and the settle time once the last report is in.
    localparam int PHASE_WORDS  = 250;
    localparam int SETTLE_CYCLES = 10;

    // One result word as it leaves the checker: m_tlast on top, then m_tdata
    // bits [221:0] from the highest field down, so that a plain cast of
    // {m_tlast, m_tdata[221:0]} fills every field.
    typedef struct packed {
        logic                        pass_done;
        logic [psc_pkg::WORD_W-1:0]  expected_sum;
        logic [psc_pkg::WORD_W-1:0]  read_sum;
        logic [psc_pkg::TOTAL_W-1:0] flip_total;
        logic                        pass_ok;
        logic [psc_pkg::FLIPS_W-1:0] word_flips;
        logic                        write_enable;
        logic [psc_pkg::WORD_W-1:0]  write_word;
    } scrub_report_t;

    // One row of the directed stimulus. On a check with xor_gold set, rd is a
    // mask of bits to flip in the golden word rather than the word itself.
    // Where fixed is set, report holds the result typed in by hand.
    typedef struct packed {
        logic [1:0]                 op;
        logic [psc_pkg::IDX_W-1:0]  idx;
        logic [psc_pkg::WORD_W-1:0] rd;
        logic                       xor_gold;
        logic                       last;
        logic                       fixed;
        scrub_report_t              report;
    } scrub_row_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [79:0]  s_tdata = '0;
    logic [1:0]   s_tuser = OP_REPORT;
    logic         s_tlast = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [223:0] m_tdata;
    logic         m_tlast;

    prbs_memory_scrub_checker dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Predictor state: golden copy, generator and the pass totals.
    logic [psc_pkg::WORD_W-1:0]  golden_mem [0:psc_pkg::WORDS-1];
    logic [6:0]                  prbs_state = psc_pkg::PRBS_SEED;
    logic [psc_pkg::WORD_W-1:0]  fill_total = '0;
    logic [psc_pkg::WORD_W-1:0]  read_total = '0;
    logic [psc_pkg::TOTAL_W-1:0] flip_acc = '0;

    // Stimulus bookkeeping: which golden entries exist, so that a check never
    // reads one that was never filled.
    bit                 filled_map [0:psc_pkg::WORDS-1];
    int                 filled_list [$];

    scrub_report_t      scrub_reports_due [$];
    scrub_row_t         directed_rows [$];
    int                 send_idle_pct = 0;
    int                 recv_stall_pct = 0;
    int                 words_sent = 0;
    int                 errors = 0;
    int                 hung_cycles = 0;

    // Works out the report for one accepted word and advances the predictor
    // state exactly as the checker should.
    function automatic scrub_report_t predict_scrub(logic [1:0] op,
                                                    logic [psc_pkg::IDX_W-1:0] idx,
                                                    logic [psc_pkg::WORD_W-1:0] rd,
                                                    logic last);
        scrub_report_t r;
        logic [psc_pkg::WORD_W-1:0] gold;
        logic [psc_pkg::WORD_W-1:0] diff;
        logic [psc_pkg::TOTAL_W:0]  acc;
        r = '0;
        case (op)
            psc_pkg::OP_FILL:
            begin
                // Eight generator steps, one state per byte, byte 0 first.
                for (int j = 0; j < 8; j++)
                begin
                    prbs_state = {prbs_state[5:0], prbs_state[6] ^ prbs_state[5]};
                    r.write_word[8*j +: 8] = {1'b0, prbs_state};
                end
                golden_mem[idx] = r.write_word;
                fill_total = fill_total + r.write_word;
                r.write_enable = 1'b1;
            end
            psc_pkg::OP_CHECK:
            begin
                gold = golden_mem[idx];
                diff = rd ^ gold;
                read_total = read_total + rd;
                r.word_flips = psc_pkg::FLIPS_W'($countones(diff));
                // The pass flip count sticks at its maximum.
                acc = {1'b0, flip_acc} + (psc_pkg::TOTAL_W+1)'(r.word_flips);
                flip_acc = acc[psc_pkg::TOTAL_W] ? psc_pkg::FLIP_MAX
                                                 : acc[psc_pkg::TOTAL_W-1:0];
                r.write_word = gold;
                r.write_enable = (diff != '0);
                if (last)
                begin
                    r.pass_done = 1'b1;
                    r.pass_ok = (read_total == fill_total) && (flip_acc == '0);
                end
            end
            psc_pkg::OP_RESTART:
            begin
                // The golden copy survives a restart.
                prbs_state = psc_pkg::PRBS_SEED;
                fill_total = '0;
                read_total = '0;
                flip_acc = '0;
            end
            default:
            begin
            end
        endcase
        // Totals are reported as they stand before a closing check clears them.
        r.flip_total = flip_acc;
        r.read_sum = read_total;
        r.expected_sum = fill_total;
        if (r.pass_done)
        begin
            read_total = '0;
            flip_acc = '0;
        end
        return r;
    endfunction

    // Offers one word to the checker, with random idle cycles in front, and
    // queues its report once the word has been taken.
    task automatic send_word(input logic [1:0] op, input logic [psc_pkg::IDX_W-1:0] idx,
                             input logic [psc_pkg::WORD_W-1:0] rd, input logic last,
                             input logic fixed, input scrub_report_t fixed_report);
        scrub_report_t predicted;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {2'b00, rd, idx};
        s_tuser <= op;
        s_tlast <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predicted = predict_scrub(op, idx, rd, last);
        scrub_reports_due.push_back(fixed ? fixed_report : predicted);
        if (op == psc_pkg::OP_FILL && !filled_map[idx])
        begin
            filled_map[idx] = 1'b1;
            filled_list.push_back(int'(idx));
        end
        if (op != OP_REPORT)
            words_sent++;
    endtask

    // Holds the sender back until every queued report has come out.
    task automatic drain_reports();
        s_tvalid <= 1'b0;
        while (scrub_reports_due.size() != 0)
            @(posedge clk);
    endtask

    // One random stretch of traffic. Most of it is a complete scrub: an
    // optional restart, a run of fills, then a verify pass over the same
    // words with the occasional corrupted read. The rest is noise: report
    // words, stray checks of filled words, lone fills and restarts, with
    // tlast set at random.
    task automatic run_scrub_sequence();
        int kind;
        int n;
        int base;
        int pick;
        logic [psc_pkg::IDX_W-1:0]  idx;
        logic [psc_pkg::WORD_W-1:0] flip_mask;
        kind = $urandom_range(0, 9);
        if (kind < 7)
        begin
            if ($urandom_range(0, 3) != 0)
                send_word(psc_pkg::OP_RESTART, psc_pkg::IDX_W'($urandom),
                          {$urandom, $urandom}, $urandom_range(0, 7) == 0, 1'b0, '0);
            n = $urandom_range(1, 10);
            base = $urandom_range(0, psc_pkg::WORDS - 1);
            for (int i = 0; i < n; i++)
                send_word(psc_pkg::OP_FILL, psc_pkg::IDX_W'(base + i), {$urandom, $urandom},
                          $urandom_range(0, 7) == 0, 1'b0, '0);
            for (int i = 0; i < n; i++)
            begin
                idx = psc_pkg::IDX_W'(base + i);
                pick = $urandom_range(0, 9);
                if (pick < 7)
                    flip_mask = '0;
                else if (pick == 7)
                    flip_mask = 64'd1 << $urandom_range(0, 63);
                else if (pick == 8)
                    flip_mask = {$urandom, $urandom};
                else
                    flip_mask = '1;
                // Now and then the pass is left open so that totals carry over.
                send_word(psc_pkg::OP_CHECK, idx, golden_mem[idx] ^ flip_mask,
                          (i == n - 1) && ($urandom_range(0, 5) != 0), 1'b0, '0);
            end
        end
        else if (kind == 7)
            send_word(OP_REPORT, psc_pkg::IDX_W'($urandom), {$urandom, $urandom},
                      $urandom_range(0, 1) != 0, 1'b0, '0);
        else if (kind == 8)
        begin
            idx = psc_pkg::IDX_W'(filled_list[$urandom_range(0, filled_list.size() - 1)]);
            send_word(psc_pkg::OP_CHECK, idx, {$urandom, $urandom},
                      $urandom_range(0, 1) != 0, 1'b0, '0);
        end
        else
            send_word(($urandom_range(0, 1) != 0) ? psc_pkg::OP_FILL : psc_pkg::OP_RESTART,
                      psc_pkg::IDX_W'($urandom), {$urandom, $urandom},
                      $urandom_range(0, 1) != 0, 1'b0, '0);
    endtask

    // Reports one field that differs from the prediction.
    task automatic compare_field(input string field, input logic [psc_pkg::WORD_W-1:0] want,
                                 input logic [psc_pkg::WORD_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, field, want, got);
            errors++;
        end
    endtask

    // Result side: random back-pressure, and every word taken is compared
    // with the oldest report still due.
    always @(posedge clk)
    begin : take_report
        scrub_report_t got;
        scrub_report_t want;
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        if (rst_n && m_tvalid && m_tready)
        begin
            got = scrub_report_t'({m_tlast, m_tdata[221:0]});
            if (scrub_reports_due.size() == 0)
            begin
                $display("%0t: result word with none expected, actual write_word 0x%0h",
                         $time, got.write_word);
                errors++;
            end
            else
            begin
                want = scrub_reports_due.pop_front();
                compare_field("write_word", want.write_word, got.write_word);
                compare_field("write_enable", 64'(want.write_enable), 64'(got.write_enable));
                compare_field("word_flips", 64'(want.word_flips), 64'(got.word_flips));
                compare_field("pass_done", 64'(want.pass_done), 64'(got.pass_done));
                compare_field("pass_ok", 64'(want.pass_ok), 64'(got.pass_ok));
                compare_field("flip_total", 64'(want.flip_total), 64'(got.flip_total));
                compare_field("read_sum", want.read_sum, got.read_sum);
                compare_field("expected_sum", want.expected_sum, got.expected_sum);
            end
        end
    end

    // Hang detector: any accepted word on either side restarts the count.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            hung_cycles <= 0;
        else
            hung_cycles <= hung_cycles + 1;
        if (hung_cycles >= HANG_LIMIT)
        begin
            $display("%0t: no word accepted for %0d cycles", $time, HANG_LIMIT);
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin : stimulus
        int target;
        int send_idle [4];
        int recv_stall [4];
        logic [psc_pkg::WORD_W-1:0] rd;
        scrub_row_t row;

        // Idling patterns per phase: none, sender mostly idle, receiver
        // mostly stalling, both now and then.
        send_idle  = '{0, 85, 0, 21};
        recv_stall = '{0, 0, 85, 21};

        // Directed words. The first five have their reports typed in: a
        // report on the reset state, the first fill, a clean closing check,
        // a check with every bit flipped, and a restart that clears it all.
        directed_rows.push_back('{OP_REPORT, 14'd0, 64'd0, 1'b0, 1'b1, 1'b1, '0});
        directed_rows.push_back('{psc_pkg::OP_FILL, 14'd0, 64'd0, 1'b0, 1'b0, 1'b1,
            '{pass_done: 1'b0, expected_sum: FIRST_FILL_WORD, read_sum: 64'd0,
              flip_total: 21'd0, pass_ok: 1'b0, word_flips: 7'd0, write_enable: 1'b1,
              write_word: FIRST_FILL_WORD}});
        directed_rows.push_back('{psc_pkg::OP_CHECK, 14'd0, 64'd0, 1'b1, 1'b1, 1'b1,
            '{pass_done: 1'b1, expected_sum: FIRST_FILL_WORD, read_sum: FIRST_FILL_WORD,
              flip_total: 21'd0, pass_ok: 1'b1, word_flips: 7'd0, write_enable: 1'b0,
              write_word: FIRST_FILL_WORD}});
        directed_rows.push_back('{psc_pkg::OP_CHECK, 14'd0, '1, 1'b1, 1'b0, 1'b1,
            '{pass_done: 1'b0, expected_sum: FIRST_FILL_WORD, read_sum: ~FIRST_FILL_WORD,
              flip_total: 21'd64, pass_ok: 1'b0, word_flips: 7'd64, write_enable: 1'b1,
              write_word: FIRST_FILL_WORD}});
        directed_rows.push_back('{psc_pkg::OP_RESTART, 14'd0, 64'd0, 1'b0, 1'b1, 1'b1, '0});
        // Fill at the top index with tlast set, which a fill ignores.
        directed_rows.push_back('{psc_pkg::OP_FILL, 14'd16383, 64'd0, 1'b0, 1'b1, 1'b0, '0});
        directed_rows.push_back('{psc_pkg::OP_FILL, 14'd1, 64'd0, 1'b0, 1'b0, 1'b0, '0});
        // Raw read words at both extremes.
        directed_rows.push_back('{psc_pkg::OP_CHECK, 14'd16383, 64'd0, 1'b0, 1'b0, 1'b0, '0});
        directed_rows.push_back('{psc_pkg::OP_CHECK, 14'd16383, '1, 1'b0, 1'b0, 1'b0, '0});
        directed_rows.push_back('{OP_REPORT, 14'd16383, '1, 1'b0, 1'b1, 1'b0, '0});
        // A single flipped bit fails the pass.
        directed_rows.push_back('{psc_pkg::OP_CHECK, 14'd1, 64'd1, 1'b1, 1'b1, 1'b0, '0});
        directed_rows.push_back('{psc_pkg::OP_RESTART, 14'd0, 64'd0, 1'b0, 1'b0, 1'b0, '0});
        directed_rows.push_back('{psc_pkg::OP_FILL, 14'h1FFF, 64'd0, 1'b0, 1'b0, 1'b0, '0});
        directed_rows.push_back('{psc_pkg::OP_FILL, 14'h2000, 64'd0, 1'b0, 1'b0, 1'b0, '0});
        directed_rows.push_back('{psc_pkg::OP_CHECK, 14'h1FFF, 64'd0, 1'b1, 1'b0, 1'b0, '0});
        directed_rows.push_back('{psc_pkg::OP_CHECK, 14'h2000, 64'd0, 1'b1, 1'b1, 1'b0, '0});
        // Entry 0 was filled before the restart and must still be there.
        directed_rows.push_back('{psc_pkg::OP_CHECK, 14'd0, 64'h8000_0000_0000_0000, 1'b1,
                                  1'b1, 1'b0, '0});
        directed_rows.push_back('{psc_pkg::OP_FILL, 14'd0, 64'd0, 1'b0, 1'b0, 1'b0, '0});
        directed_rows.push_back('{psc_pkg::OP_CHECK, 14'd0, 64'd0, 1'b1, 1'b0, 1'b0, '0});
        directed_rows.push_back('{OP_REPORT, 14'd0, 64'd0, 1'b0, 1'b0, 1'b0, '0});

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            rd = (row.xor_gold && row.op == psc_pkg::OP_CHECK) ? (golden_mem[row.idx] ^ row.rd)
                                                               : row.rd;
            send_word(row.op, row.idx, rd, row.last, row.fixed, row.report);
        end

        // Random phases; the sender waits for every report between phases.
        target = words_sent;
        for (int phase = 0; phase < 4; phase++)
        begin
            drain_reports();
            send_idle_pct = send_idle[phase];
            recv_stall_pct = recv_stall[phase];
            target += PHASE_WORDS;
            while (words_sent < target)
                run_scrub_sequence();
        end

        drain_reports();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

FILE: sim.f
hdl/psc_pkg.sv
hdl/psc_front.sv
hdl/psc_queue.sv
hdl/psc_back.sv
hdl/prbs_memory_scrub_checker.sv
test/tb_prbs_memory_scrub_checker.sv
